FILE: hdl/atlr_pkg.sv
// Shared types and constants of the anti-aliased thick line rasterizer.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package atlr_pkg;

  localparam int CANVAS_BITS = 13;
  localparam int CFG_IDX_BITS = 1;
  localparam int RGB_BITS = 24;
  localparam int THK_BITS = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_WIDTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_HEIGHT = 1'b1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  localparam logic [CANVAS_BITS-1:0] CANVAS_W_RST = 13'd640;
  localparam logic [CANVAS_BITS-1:0] CANVAS_H_RST = 13'd480;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQA,
    ST_SQB,
    ST_ROOT,
    ST_WALK,
    ST_COV0,
    ST_COV1,
    ST_DIV,
    ST_SETTLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic sq_a;
    logic sq_b;
    logic root_step;
    logic walk_step;
    logic cov_a;
    logic cov_b;
    logic div_step;
    logic promote;
    logic emit;
    logic emit_last;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic action;
    logic pend_v;
    logic walk_found;
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: hdl/atlr_ctrl.sv
// Sequencer of the rasterizer: steps the squaring, root, walk, setup, divide, settle and emit phases.
// Depends on atlr_pkg; drives atlr_dp through cmd_t and reads sts_t.
`default_nettype none
module atlr_ctrl #(
  parameter int ROOT_STEPS = 22
) (
  input  wire              clk,
  input  wire              rst_n,
  input  atlr_pkg::sts_t   sts,
  output logic             in_ready,
  output atlr_pkg::cmd_t   cmd
);

  localparam int RCW = $clog2(ROOT_STEPS);

  atlr_pkg::state_t state_r, state_nxt;
  logic [RCW-1:0] root_cnt_r, root_cnt_nxt;
  logic [2:0] step_cnt_r, step_cnt_nxt;
  logic first_r, first_nxt;
  logic last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= atlr_pkg::ST_IDLE;
      root_cnt_r <= '0;
      step_cnt_r <= '0;
      first_r    <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      root_cnt_r <= root_cnt_nxt;
      step_cnt_r <= step_cnt_nxt;
      first_r    <= first_nxt;
      last_r     <= last_nxt;
    end
  end

  // Next state and counters.
  always_comb begin
    state_nxt    = state_r;
    root_cnt_nxt = root_cnt_r;
    step_cnt_nxt = step_cnt_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    unique case (state_r)
      atlr_pkg::ST_IDLE: begin
        if (sts.in_valid) begin
          if (sts.action == atlr_pkg::ACT_LOAD) begin
            state_nxt = atlr_pkg::ST_SQA;
            first_nxt = 1'b1;
          end else if (sts.pend_v) begin
            state_nxt    = atlr_pkg::ST_WALK;
            step_cnt_nxt = '0;
            first_nxt    = 1'b0;
          end
        end
      end
      atlr_pkg::ST_SQA: state_nxt = atlr_pkg::ST_SQB;
      atlr_pkg::ST_SQB: begin
        state_nxt    = atlr_pkg::ST_ROOT;
        root_cnt_nxt = '0;
      end
      atlr_pkg::ST_ROOT: begin
        root_cnt_nxt = root_cnt_r + 1'b1;
        if (root_cnt_r == RCW'(ROOT_STEPS - 1)) begin
          state_nxt    = atlr_pkg::ST_WALK;
          step_cnt_nxt = '0;
        end
      end
      atlr_pkg::ST_WALK: begin
        step_cnt_nxt = step_cnt_r + 1'b1;
        if (sts.walk_found) begin
          state_nxt = atlr_pkg::ST_COV0;
        end else if (sts.walk_end || step_cnt_r == 3'd7) begin
          last_nxt  = 1'b1;
          state_nxt = first_r ? atlr_pkg::ST_IDLE : atlr_pkg::ST_EMIT;
        end
      end
      atlr_pkg::ST_COV0: state_nxt = atlr_pkg::ST_COV1;
      atlr_pkg::ST_COV1: begin
        state_nxt    = atlr_pkg::ST_DIV;
        step_cnt_nxt = '0;
      end
      atlr_pkg::ST_DIV: begin
        step_cnt_nxt = step_cnt_r + 1'b1;
        if (step_cnt_r == 3'd7) state_nxt = atlr_pkg::ST_SETTLE;
      end
      atlr_pkg::ST_SETTLE: begin
        last_nxt  = 1'b0;
        state_nxt = first_r ? atlr_pkg::ST_IDLE : atlr_pkg::ST_EMIT;
      end
      atlr_pkg::ST_EMIT: begin
        if (sts.out_free) state_nxt = atlr_pkg::ST_IDLE;
      end
      default: state_nxt = atlr_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      atlr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = sts.in_valid && (sts.action == atlr_pkg::ACT_LOAD);
      end
      atlr_pkg::ST_SQA:  cmd.sq_a = 1'b1;
      atlr_pkg::ST_SQB:  cmd.sq_b = 1'b1;
      atlr_pkg::ST_ROOT: cmd.root_step = 1'b1;
      atlr_pkg::ST_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.finish = first_r && !sts.walk_found && (sts.walk_end || step_cnt_r == 3'd7);
      end
      atlr_pkg::ST_COV0: cmd.cov_a = 1'b1;
      atlr_pkg::ST_COV1: cmd.cov_b = 1'b1;
      atlr_pkg::ST_DIV:  cmd.div_step = 1'b1;
      atlr_pkg::ST_SETTLE: cmd.promote = first_r;
      atlr_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = last_r;
          cmd.promote   = !last_r;
          cmd.finish    = last_r;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/atlr_dp.sv
// Datapath of the rasterizer: walk state, integer square root, coverage
// divider, pending pixel and output register. Depends on atlr_pkg.
`default_nettype none
module atlr_dp #(
  parameter int COORD_BITS = 13,
  parameter int MAX_WIDTH  = 15
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  atlr_pkg::cmd_t                       cmd,
  output atlr_pkg::sts_t                       sts,
  input  wire                                  in_valid,
  input  wire                                  in_action,
  input  wire signed [COORD_BITS-1:0]          in_x0,
  input  wire signed [COORD_BITS-1:0]          in_y0,
  input  wire signed [COORD_BITS-1:0]          in_x1,
  input  wire signed [COORD_BITS-1:0]          in_y1,
  input  wire [atlr_pkg::THK_BITS-1:0]         in_thk,
  input  wire [atlr_pkg::RGB_BITS-1:0]         in_rgb,
  input  wire                                  cfg_wr_en,
  input  wire [atlr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire [atlr_pkg::CANVAS_BITS-1:0]      cfg_wdata,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [COORD_BITS-1:0]         out_x,
  output logic signed [COORD_BITS-1:0]         out_y,
  output logic [7:0]                           out_alpha,
  output logic [atlr_pkg::RGB_BITS-1:0]        out_rgb,
  output logic                                 out_on,
  output logic                                 out_last
);

  localparam int SPW = COORD_BITS;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CW  = COORD_BITS + WW + 1;
  localparam int EW  = COORD_BITS + 3;
  localparam int IW  = COORD_BITS + WW + 3;
  localparam int SQW = 2 * COORD_BITS + 18;
  localparam int LW  = SQW / 2;
  localparam int MW  = IW + 9;
  localparam int TW  = IW + WW + 10;
  localparam int NW  = TW + 8;
  localparam int DW  = NW + 2;
  localparam int OW  = CW + atlr_pkg::CANVAS_BITS + 1;
  localparam int PW  = 2 * SPW + 1;

  // Walk state.
  logic [1:0] phase_r, phase_nxt;
  logic signed [CW-1:0] cur_x_r, cur_y_r, side_x_r, side_y_r, tgt_x_r, tgt_y_r;
  logic signed [CW-1:0] cur_x_nxt, cur_y_nxt, side_x_nxt, side_y_nxt;
  logic [SPW-1:0] span_x_r, span_y_r;
  logic [1:0] signs_r;
  logic signed [EW-1:0] err_r, err_nxt, saved_r, saved_nxt;
  logic signed [IW-1:0] inner_r, inner_nxt;
  logic [WW-1:0] wd_r;
  logic [atlr_pkg::RGB_BITS-1:0] rgb_r;
  logic span_zero_r;

  // Square root.
  logic [PW-1:0] acc_r;
  logic [SQW-1:0] n_r, res_r, bit_r, root_sum;
  logic [LW-1:0] len;

  // Candidate and pending pixels.
  logic signed [CW-1:0] cand_x_r, cand_y_r, cand_x_nxt, cand_y_nxt;
  logic signed [IW-1:0] cand_err_r, cand_err_nxt;
  logic signed [CW-1:0] pend_x_r, pend_y_r;
  logic [7:0] pend_alpha_r;
  logic pend_v_r;

  // Coverage divider.
  logic signed [TW-1:0] t_r;
  logic [DW-1:0] rem_r, dv_r;
  logic [7:0] q_r;
  logic nonpos_r, sat_r;
  logic [7:0] alpha;

  logic [atlr_pkg::CANVAS_BITS-1:0] canvas_w_r, canvas_h_r;

  logic found, walk_end;

  assign len = span_zero_r ? LW'(256) : res_r[LW-1:0];

  // Load-time decode.
  logic signed [CW-1:0] x0e, y0e, x1e, y1e, ddx, ddy;
  logic [SPW-1:0] sx_ld, sy_ld;
  logic [WW-1:0] wd_ld;
  always_comb begin
    x0e = CW'(in_x0);
    y0e = CW'(in_y0);
    x1e = CW'(in_x1);
    y1e = CW'(in_y1);
    ddx = x1e - x0e;
    ddy = y1e - y0e;
    sx_ld = ddx[CW-1] ? SPW'(-ddx) : SPW'(ddx);
    sy_ld = ddy[CW-1] ? SPW'(-ddy) : SPW'(ddy);
    if (in_thk == '0) wd_ld = WW'(1);
    else if (8'(in_thk) > 8'(MAX_WIDTH)) wd_ld = WW'(MAX_WIDTH);
    else wd_ld = WW'(in_thk);
  end

  // One iteration of the walk loop.
  logic signed [CW-1:0] stp_x, stp_y;
  logic signed [EW:0] sxe, sye, e2;
  logic signed [IW-1:0] sxi, syi;
  logic signed [MW-1:0] in_lhs, in_rhs;
  logic in_width;
  always_comb begin
    stp_x = signs_r[0] ? -CW'(1) : CW'(1);
    stp_y = signs_r[1] ? -CW'(1) : CW'(1);
    sxe = (EW+1)'({1'b0, span_x_r});
    sye = (EW+1)'({1'b0, span_y_r});
    sxi = IW'({1'b0, span_x_r});
    syi = IW'({1'b0, span_y_r});
    in_lhs = MW'(inner_r) <<< 8;
    in_rhs = MW'({1'b0, (LW+WW)'(len) * (LW+WW)'(wd_r)});
    in_width = in_lhs < in_rhs;
    phase_nxt = phase_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    side_x_nxt = side_x_r;
    side_y_nxt = side_y_r;
    err_nxt = err_r;
    saved_nxt = saved_r;
    inner_nxt = inner_r;
    cand_x_nxt = cand_x_r;
    cand_y_nxt = cand_y_r;
    cand_err_nxt = cand_err_r;
    found = 1'b0;
    walk_end = 1'b0;
    e2 = '0;
    unique case (phase_r)
      2'd0: begin
        found = 1'b1;
        cand_x_nxt = cur_x_r;
        cand_y_nxt = cur_y_r;
        cand_err_nxt = IW'((EW+1)'(err_r) - sxe + sye);
        saved_nxt = err_r;
        side_x_nxt = cur_x_r;
        e2 = (EW+1)'(err_r) <<< 1;
        if (e2 >= -sxe) begin
          inner_nxt = IW'(err_r) + syi;
          side_y_nxt = cur_y_r;
          phase_nxt = 2'd1;
        end else if (e2 <= sye) begin
          inner_nxt = sxi - IW'(err_r);
          phase_nxt = 2'd2;
        end else begin
          phase_nxt = 2'd0;
        end
      end
      2'd1: begin
        if (in_width && (tgt_y_r != side_y_r || span_x_r > span_y_r)) begin
          found = 1'b1;
          side_y_nxt = side_y_r + stp_y;
          cand_x_nxt = cur_x_r;
          cand_y_nxt = side_y_r + stp_y;
          cand_err_nxt = inner_r;
          inner_nxt = inner_r + sxi;
        end else if (cur_x_r == tgt_x_r) begin
          walk_end = 1'b1;
        end else begin
          err_nxt = err_r - EW'(sye);
          cur_x_nxt = cur_x_r + stp_x;
          e2 = (EW+1)'(saved_r) <<< 1;
          if (e2 <= sye) begin
            inner_nxt = sxi - IW'(saved_r);
            phase_nxt = 2'd2;
          end else begin
            phase_nxt = 2'd0;
          end
        end
      end
      default: begin
        if (in_width && (tgt_x_r != side_x_r || span_x_r < span_y_r)) begin
          found = 1'b1;
          side_x_nxt = side_x_r + stp_x;
          cand_x_nxt = side_x_r + stp_x;
          cand_y_nxt = cur_y_r;
          cand_err_nxt = inner_r;
          inner_nxt = inner_r + syi;
        end else if (cur_y_r == tgt_y_r) begin
          walk_end = 1'b1;
        end else begin
          err_nxt = err_r + EW'(sxe);
          cur_y_nxt = cur_y_r + stp_y;
          phase_nxt = 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      span_x_r <= sx_ld;
      span_y_r <= sy_ld;
      signs_r <= {!(in_y0 < in_y1), !(in_x0 < in_x1)};
      cur_x_r <= x0e;
      cur_y_r <= y0e;
      side_x_r <= x0e;
      side_y_r <= y0e;
      tgt_x_r <= x1e;
      tgt_y_r <= y1e;
      err_r <= EW'({1'b0, sx_ld}) - EW'({1'b0, sy_ld});
      inner_r <= '0;
      saved_r <= '0;
      wd_r <= wd_ld;
      rgb_r <= in_rgb;
      span_zero_r <= (sx_ld == '0) && (sy_ld == '0);
      phase_r <= 2'd0;
    end else if (cmd.walk_step && !walk_end) begin
      phase_r <= phase_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      side_x_r <= side_x_nxt;
      side_y_r <= side_y_nxt;
      err_r <= err_nxt;
      saved_r <= saved_nxt;
      inner_r <= inner_nxt;
      cand_x_r <= cand_x_nxt;
      cand_y_r <= cand_y_nxt;
      cand_err_r <= cand_err_nxt;
    end
  end

  // Bit-pair square root, one result bit per step.
  assign root_sum = res_r + bit_r;
  always_ff @(posedge clk) begin
    if (cmd.sq_a) begin
      acc_r <= PW'(span_x_r) * PW'(span_x_r);
    end else if (cmd.sq_b) begin
      n_r <= SQW'(acc_r + PW'(span_y_r) * PW'(span_y_r)) << 16;
      res_r <= '0;
      bit_r <= SQW'(1) << (SQW - 2);
    end else if (cmd.root_step) begin
      if (n_r >= root_sum) begin
        n_r <= n_r - root_sum;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Coverage: 255*(|err|*256 - (wd-1)*len), rounded over len.
  logic signed [IW-1:0] abs_err;
  logic signed [NW-1:0] num;
  logic [DW-1:0] dnum, dden;
  always_comb begin
    abs_err = cand_err_r[IW-1] ? -cand_err_r : cand_err_r;
    num = (NW'(t_r) <<< 8) - NW'(t_r);
    dnum = DW'(num) <<< 1;
    dnum = dnum + DW'(len);
    dden = DW'(len) << 1;
    if (nonpos_r) alpha = 8'd255;
    else if (sat_r) alpha = 8'd0;
    else alpha = 8'd255 - q_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.cov_a) begin
      t_r <= (TW'(abs_err) <<< 8)
           - TW'({1'b0, (LW+WW)'(len) * (LW+WW)'(wd_r - WW'(1))});
    end else if (cmd.cov_b) begin
      nonpos_r <= (num <= 0);
      sat_r <= dnum >= (dden << 8);
      rem_r <= dnum;
      dv_r <= dden << 7;
      q_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dv_r) begin
        rem_r <= rem_r - dv_r;
        q_r <= {q_r[6:0], 1'b1};
      end else begin
        q_r <= {q_r[6:0], 1'b0};
      end
      dv_r <= dv_r >> 1;
    end
  end

  // Pending pixel and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.load || cmd.finish) begin
      pend_v_r <= 1'b0;
    end else if (cmd.promote) begin
      pend_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.promote) begin
      pend_x_r <= cand_x_r;
      pend_y_r <= cand_y_r;
      pend_alpha_r <= alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r <= atlr_pkg::CANVAS_W_RST;
      canvas_h_r <= atlr_pkg::CANVAS_H_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == atlr_pkg::REG_CANVAS_WIDTH) canvas_w_r <= cfg_wdata;
      if (cfg_index == atlr_pkg::REG_CANVAS_HEIGHT) canvas_h_r <= cfg_wdata;
    end
  end

  logic on_c;
  always_comb begin
    on_c = (pend_x_r >= 0) && (OW'(pend_x_r) < OW'({1'b0, canvas_w_r}))
        && (pend_y_r >= 0) && (OW'(pend_y_r) < OW'({1'b0, canvas_h_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x <= pend_x_r[COORD_BITS-1:0];
      out_y <= pend_y_r[COORD_BITS-1:0];
      out_alpha <= pend_alpha_r;
      out_rgb <= rgb_r;
      out_on <= on_c;
      out_last <= cmd.emit_last;
    end
  end

  always_comb begin
    sts.in_valid = in_valid;
    sts.action = in_action;
    sts.pend_v = pend_v_r;
    sts.walk_found = found;
    sts.walk_end = walk_end;
    sts.out_free = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

FILE: hdl/antialiased_thick_line_raster.sv
// Top level of the anti-aliased thick line rasterizer.
// Depends on atlr_pkg, atlr_ctrl and atlr_dp.
//
// A load word latches two endpoints, a width and a color, then the block
// squares the two spans, computes the line length as an integer square root
// in 14.8 fixed point (one result bit per cycle) and walks to the first
// pixel and its coverage. Each advance word returns one pixel of the walk:
// the walk runs up to eight loop iterations, the coverage term is set up and
// then reduced by an eight-bit restoring divide, and the block then settles
// and emits. The advance that finds the line ended skips the divide, and a
// result word still waiting on the output register holds the block in its
// emit state until it is taken. The block keeps one pixel in hand so that
// it can flag the final pixel with tlast. An advance with no line active
// returns nothing and is taken at once; a load abandons any line in
// progress. Pixels outside the canvas are still returned with on_canvas
// cleared. The input is taken again as soon as the block is idle, even
// while a result word is still waiting on the output register.
`default_nettype none
module antialiased_thick_line_raster #(
  parameter int COORD_BITS = 13,
  parameter int MAX_WIDTH  = 15
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // start_x, start_y, end_x, end_y, thickness, line_rgb (from bit 0 up)
  input  wire [((4*COORD_BITS+28+7)/8)*8-1:0] in_tdata,
  // action
  input  wire                              in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // pixel_x, pixel_y, pixel_alpha, pixel_rgb (from bit 0 up)
  output logic [((2*COORD_BITS+32+7)/8)*8-1:0] out_tdata,
  // on_canvas
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  wire                              cfg_wr_en,
  input  wire [atlr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire [atlr_pkg::CANVAS_BITS-1:0]  cfg_wdata
);

  localparam int OUT_DW = ((2*COORD_BITS+32+7)/8)*8;
  localparam int ROOT_STEPS = COORD_BITS + 9;
  localparam int OFS_THK = 4 * COORD_BITS;
  localparam int OFS_RGB = OFS_THK + atlr_pkg::THK_BITS;

  atlr_pkg::cmd_t cmd;
  atlr_pkg::sts_t sts;

  logic signed [COORD_BITS-1:0] px, py;
  logic [7:0] pa;
  logic [atlr_pkg::RGB_BITS-1:0] prgb;

  atlr_ctrl #(.ROOT_STEPS(ROOT_STEPS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  atlr_dp #(.COORD_BITS(COORD_BITS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .in_x0     (in_tdata[COORD_BITS-1:0]),
    .in_y0     (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_x1     (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .in_y1     (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .in_thk    (in_tdata[OFS_THK +: atlr_pkg::THK_BITS]),
    .in_rgb    (in_tdata[OFS_RGB +: atlr_pkg::RGB_BITS]),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (px),
    .out_y     (py),
    .out_alpha (pa),
    .out_rgb   (prgb),
    .out_on    (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = OUT_DW'({prgb, pa, py, px});

endmodule
`default_nettype wire

FILE: hdl/atlr_checker.sv
// Port-level checks of the rasterizer and their bind to the top level.
// Depends on antialiased_thick_line_raster.
`default_nettype none
module atlr_checker #(
  parameter int OUT_DW = 64
) (
  input wire              clk,
  input wire              rst_n,
  input wire              in_tvalid,
  input wire              in_tready,
  input wire              in_tuser,
  input wire              out_tvalid,
  input wire              out_tready,
  input wire [OUT_DW-1:0] out_tdata,
  input wire              out_tlast
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  // Reset leaves no result word behind.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A load starts the length computation, so the input closes next cycle.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !in_tready)
    else $error("input open right after a load");

  // A new result word only comes out of a cycle with the input closed.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result word raised while the input was open");

endmodule

bind antialiased_thick_line_raster atlr_checker #(
  .OUT_DW (((2*COORD_BITS+32+7)/8)*8)
) u_atlr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

FILE: tb/tb.sv
// Testbench for antialiased_thick_line_raster: drives load and advance words,
// predicts every pixel of the thick anti-aliased walk and checks the results.
// Depends on atlr_pkg and the antialiased_thick_line_raster RTL only.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 13;
  localparam int IN_W = ((4*CB+28+7)/8)*8;
  localparam int OUT_W = ((2*CB+32+7)/8)*8;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;

  // One expected pixel, at the widths of the result word.
  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [7:0]    alpha;
    logic [23:0]   rgb;
    bit            on_canvas;
    bit            last;
  } pixel_t;

  // Walker state; coordinates are held wide so that side pixels beyond the
  // coordinate range keep their true position for the canvas test.
  typedef struct {
    bit          busy;
    int          phase;
    longint      cur_x, cur_y, side_x, side_y, tgt_x, tgt_y;
    longint      span_x, span_y;
    bit [1:0]    signs;
    longint      err, inner, saved, len_q8, wd;
    logic [23:0] rgb;
  } walker_t;

  // Scoreboard: runs the line walker on each accepted word and keeps the
  // pixels still owed by the block.
  class pixel_scoreboard;
    walker_t     line;
    int unsigned canvas_w = 640;
    int unsigned canvas_h = 480;
    pixel_t      owed[$];
    int          errors = 0;
    int          checked = 0;

    function new();
      line = '{default: 0};
      line.len_q8 = 256;
      line.wd = 1;
    endfunction

    task report(string what, longint got, longint want);
      $display("ERROR at %0t: pixel %0d %s got 0x%0h want 0x%0h",
               $realtime, checked, what, got, want);
      errors++;
    endtask

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function int unsigned coverage_alpha(walker_t w, longint e);
      longint num, q;
      if (e < 0) e = -e;
      num = 255 * (e * 256 - (w.wd - 1) * w.len_q8);
      if (num <= 0) return 255;
      q = (2 * num + w.len_q8) / (2 * w.len_q8);
      if (q > 255) q = 255;
      return 255 - q;
    endfunction

    function void enter_y(ref walker_t w);
      if (2 * w.saved <= w.span_y) begin
        w.inner = w.span_x - w.saved;
        w.phase = 2;
      end else begin
        w.phase = 0;
      end
    endfunction

    // Moves the walk to its next pixel; returns 0 once the line is done.
    function bit walk(ref walker_t w, output longint px, output longint py,
                      output int unsigned a);
      longint dx, dy;
      px = 0;
      py = 0;
      a = 0;
      dx = w.signs[0] ? -1 : 1;
      dy = w.signs[1] ? -1 : 1;
      for (int g = 0; g < 8; g++) begin
        if (!w.busy) return 0;
        if (w.phase == 0) begin
          px = w.cur_x;
          py = w.cur_y;
          a = coverage_alpha(w, w.err - w.span_x + w.span_y);
          w.saved = w.err;
          w.side_x = w.cur_x;
          if (2 * w.err >= -w.span_x) begin
            w.inner = w.err + w.span_y;
            w.side_y = w.cur_y;
            w.phase = 1;
          end else begin
            enter_y(w);
          end
          return 1;
        end else if (w.phase == 1) begin
          if (w.inner * 256 < w.len_q8 * w.wd &&
              (w.tgt_y != w.side_y || w.span_x > w.span_y)) begin
            w.side_y += dy;
            px = w.cur_x;
            py = w.side_y;
            a = coverage_alpha(w, w.inner);
            w.inner += w.span_x;
            return 1;
          end
          if (w.cur_x == w.tgt_x) begin
            w.busy = 0;
            return 0;
          end
          w.err -= w.span_y;
          w.cur_x += dx;
          enter_y(w);
        end else begin
          if (w.inner * 256 < w.len_q8 * w.wd &&
              (w.tgt_x != w.side_x || w.span_x < w.span_y)) begin
            w.side_x += dx;
            px = w.side_x;
            py = w.cur_y;
            a = coverage_alpha(w, w.inner);
            w.inner += w.span_y;
            return 1;
          end
          if (w.cur_y == w.tgt_y) begin
            w.busy = 0;
            return 0;
          end
          w.err += w.span_x;
          w.cur_y += dy;
          w.phase = 0;
        end
      end
      w.busy = 0;
      return 0;
    endfunction

    // Called for every word the block accepts.
    function void note_word(logic act, longint x0, longint y0, longint x1,
                            longint y1, int thk, logic [23:0] rgb);
      walker_t     look;
      longint      px, py, qx, qy;
      int unsigned a, b;
      pixel_t      p;
      bit          fin;
      if (act == atlr_pkg::ACT_LOAD) begin
        line.span_x = (x1 > x0) ? x1 - x0 : x0 - x1;
        line.span_y = (y1 > y0) ? y1 - y0 : y0 - y1;
        line.signs = {y0 < y1 ? 1'b0 : 1'b1, x0 < x1 ? 1'b0 : 1'b1};
        line.cur_x = x0;
        line.cur_y = y0;
        line.side_x = x0;
        line.side_y = y0;
        line.tgt_x = x1;
        line.tgt_y = y1;
        line.err = line.span_x - line.span_y;
        line.inner = 0;
        line.saved = 0;
        line.len_q8 = (line.span_x + line.span_y == 0) ? 256 :
          longint'(int_sqrt(longint'(line.span_x * line.span_x +
                                     line.span_y * line.span_y) << 16));
        line.wd = (thk < 1) ? 1 : (thk > 15) ? 15 : thk;
        line.rgb = rgb;
        line.phase = 0;
        line.busy = 1;
        return;
      end
      if (!walk(line, px, py, a)) return;
      look = line;
      fin = !walk(look, qx, qy, b);
      if (fin) line.busy = 0;
      p.x = px[CB-1:0];
      p.y = py[CB-1:0];
      p.alpha = a[7:0];
      p.rgb = line.rgb;
      p.on_canvas = px >= 0 && px < canvas_w && py >= 0 && py < canvas_h;
      p.last = fin;
      owed.push_back(p);
    endfunction

    // Called for every result word the block hands over.
    task check_pixel(logic [OUT_W-1:0] d, logic on_c, logic lst);
      pixel_t p;
      checked++;
      if (owed.size() == 0) begin
        report("unexpected word", d, 0);
        return;
      end
      p = owed.pop_front();
      if (d[12:0] !== p.x) report("pixel_x", d[12:0], p.x);
      if (d[25:13] !== p.y) report("pixel_y", d[25:13], p.y);
      if (d[33:26] !== p.alpha) report("pixel_alpha", d[33:26], p.alpha);
      if (d[57:34] !== p.rgb) report("pixel_rgb", d[57:34], p.rgb);
      if (on_c !== p.on_canvas) report("on_canvas", on_c, p.on_canvas);
      if (lst !== p.last) report("last", lst, p.last);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [atlr_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [atlr_pkg::CANVAS_BITS-1:0] cfg_wdata = '0;

  antialiased_thick_line_raster i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  pixel_scoreboard sb = new();
  int words_sent = 0;
  int lines_sent = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  // Result monitor: every accepted result word goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_pixel(out_tdata, out_tuser, out_tlast);
  end

  // Receiver: a long hold-off when one is requested, otherwise a stall
  // pattern that switches at random between always-ready stretches, light stalls and heavy stalls.
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog: counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("antialiased_thick_line_raster: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one word and waits until the block takes it. The sender works in
  // bursts; between bursts valid often drops for a random gap.
  task send_word(logic act, longint x0, longint y0, longint x1, longint y1,
                 int thk, logic [23:0] rgb);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {rgb, thk[3:0], y1[CB-1:0], x1[CB-1:0], y0[CB-1:0], x0[CB-1:0]};
    do @(posedge clk); while (!in_tready);
    sb.note_word(act, x0, y0, x1, y1, thk, rgb);
    words_sent++;
    if (act == atlr_pkg::ACT_LOAD) lines_sent++;
  endtask

  task advance(int n);
    repeat (n) send_word(atlr_pkg::ACT_ADVANCE, $urandom, $urandom, $urandom,
                         $urandom, $urandom_range(0, 15), $urandom);
  endtask

  task load_line(longint x0, longint y0, longint x1, longint y1, int thk,
                 logic [23:0] rgb);
    send_word(atlr_pkg::ACT_LOAD, x0, y0, x1, y1, thk, rgb);
  endtask

  // Stops offering words until every owed pixel has arrived, then lets the
  // block finish any advance that produces nothing.
  task drain();
    in_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task set_canvas(int unsigned w, int unsigned h);
    cfg_wr_en <= 1'b1;
    cfg_index <= atlr_pkg::REG_CANVAS_WIDTH;
    cfg_wdata <= w[atlr_pkg::CANVAS_BITS-1:0];
    @(posedge clk);
    cfg_index <= atlr_pkg::REG_CANVAS_HEIGHT;
    cfg_wdata <= h[atlr_pkg::CANVAS_BITS-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.canvas_w = w;
    sb.canvas_h = h;
  endtask

  function longint clip_coord(longint v);
    return (v < -4096) ? -4096 : (v > 4095) ? 4095 : v;
  endfunction

  // A random short line followed by roughly as many advances as it has
  // pixels; sometimes the line is cut short by the next load.
  task random_line();
    longint x0, y0, x1, y1;
    int thk, span, n;
    x0 = longint'($urandom_range(0, 8191)) - 4096;
    y0 = longint'($urandom_range(0, 8191)) - 4096;
    thk = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
    span = (thk > 8) ? 4 : 12;
    x1 = clip_coord(x0 + $urandom_range(0, 2 * span) - span);
    y1 = clip_coord(y0 + $urandom_range(0, 2 * span) - span);
    load_line(x0, y0, x1, y1, thk, $urandom);
    n = (span + 1) * (thk + 2) + 3;
    if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
    advance(n);
  endtask

  // Noise: fully random loads with a few advances, and stray advances.
  task random_noise();
    if ($urandom_range(0, 1) == 0) begin
      load_line(longint'($urandom_range(0, 8191)) - 4096,
                longint'($urandom_range(0, 8191)) - 4096,
                longint'($urandom_range(0, 8191)) - 4096,
                longint'($urandom_range(0, 8191)) - 4096,
                $urandom_range(0, 15), $urandom);
      advance($urandom_range(0, 20));
    end else begin
      advance($urandom_range(1, 4));
    end
  endtask

  task random_phase(int words);
    int stop;
    stop = words_sent + words;
    while (words_sent < stop) begin
      if ($urandom_range(0, 6) == 0) random_noise();
      else random_line();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An advance with no line active gives nothing.
    advance(2);
    // A degenerate line is a single pixel with last set.
    load_line(5, 7, 5, 7, 1, 24'hffffff);
    advance(2);
    // Zero thickness is taken as one; color all zeros.
    load_line(0, 0, 6, 3, 0, 24'h000000);
    advance(8);
    // A new load abandons the line in progress.
    load_line(-4096, -4096, 4095, 4095, 15, 24'h5a5a5a);
    advance(3);
    // Wide line from the top corner: its side pixels run inward, toward lower coordinates.
    load_line(4095, 4095, 4093, 4091, 15, 24'ha5a5a5);
    advance(3);
    drain();

    // Smallest canvas, then one covering every non-negative coordinate, with wide lines near the edges.
    set_canvas(1, 1);
    load_line(-2, 1, 2, -1, 3, 24'h123456);
    advance(20);
    drain();
    set_canvas(4096, 4096);
    load_line(4090, 4094, 4095, 4090, 4, 24'h0f0f0f);
    advance(40);
    random_phase(350);
    drain();

    // Back to the reset canvas; the receiver holds off long enough for the
    // block to fill up and stall its input.
    set_canvas(640, 480);
    hold_req <= 1'b1;
    random_phase(350);
    drain();

    set_canvas($urandom_range(1, 4096), $urandom_range(1, 4096));
    random_phase(375);
    drain();

    set_canvas($urandom_range(1, 64), $urandom_range(1, 64));
    random_phase(375);
    drain();

    $display("covered %0d words over %0d lines, %0d pixels checked",
             words_sent, lines_sent, sb.checked);
    $display("canvas settings from 1x1 to 4096x4096, widths 0 to 15");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("antialiased_thick_line_raster: match");
    end else begin
      $display("%0d errors, %0d pixels never arrived", sb.errors, sb.owed.size());
      $display("antialiased_thick_line_raster: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
